// File: design/stpc_pkg.sv
// Shared types and constants for the spanning-tree configuration engine.
// No dependencies; every other design file imports this package.
package stpc_pkg;

  // Fixed field widths of the channels
  localparam int ID_W      = 8;
  localparam int DIST_W    = 8;
  localparam int PORT_W    = 3;
  localparam int MASK_W    = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;

  // Defaults for the top-level parameters
  localparam int NUM_PORTS_DEF = 8;
  localparam int ID_WIDTH_DEF  = 8;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_ID      = 1'b0,
    CFG_PORT_ENABLE = 1'b1
  } cfg_reg_e;

  // Request kinds
  typedef enum logic {
    REQ_RECEIVED  = 1'b0,
    REQ_ORIGINATE = 1'b1
  } req_kind_e;

  // One request item
  typedef struct packed {
    logic              req_type;
    logic [ID_W-1:0]   msg_root;
    logic [DIST_W-1:0] msg_distance;
    logic [ID_W-1:0]   msg_sender;
    logic [PORT_W-1:0] arrival_port;
  } req_t;

  // One result item
  typedef struct packed {
    logic              send_valid;
    logic [ID_W-1:0]   out_root;
    logic [DIST_W-1:0] out_distance;
    logic [ID_W-1:0]   out_sender;
    logic [MASK_W-1:0] send_port_mask;
    logic [MASK_W-1:0] designated_mask;
    logic [PORT_W-1:0] root_port;
    logic              root_port_valid;
  } res_t;

  // Register write toward the engine
  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
  } cfg_wr_t;

endpackage

// File: design/stpc_if.sv
// Valid/ready channel interfaces: request, result and register write.
// Depends on stpc_pkg for field widths.
interface stpc_req_if;
  import stpc_pkg::*;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ID_W-1:0]   msg_root;
  logic [DIST_W-1:0] msg_distance;
  logic [ID_W-1:0]   msg_sender;
  logic [PORT_W-1:0] arrival_port;

  modport source (output valid, req_type, msg_root, msg_distance, msg_sender, arrival_port,
                  input ready);
  modport sink   (input valid, req_type, msg_root, msg_distance, msg_sender, arrival_port,
                  output ready);
endinterface

interface stpc_res_if;
  import stpc_pkg::*;
  logic              valid;
  logic              ready;
  logic              send_valid;
  logic [ID_W-1:0]   out_root;
  logic [DIST_W-1:0] out_distance;
  logic [ID_W-1:0]   out_sender;
  logic [MASK_W-1:0] send_port_mask;
  logic [MASK_W-1:0] designated_mask;
  logic [PORT_W-1:0] root_port;
  logic              root_port_valid;

  modport source (output valid, send_valid, out_root, out_distance, out_sender,
                  send_port_mask, designated_mask, root_port, root_port_valid,
                  input ready);
  modport sink   (input valid, send_valid, out_root, out_distance, out_sender,
                  send_port_mask, designated_mask, root_port, root_port_valid,
                  output ready);
endinterface

interface stpc_cfg_if;
  import stpc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/stpc_engine.sv
// Bridge state, configuration registers and the per-message decision logic.
// Depends on stpc_pkg; instantiated by stp_config_bpdu_processor.
module stpc_engine #(
  parameter int NumPorts = stpc_pkg::NUM_PORTS_DEF,
  parameter int IdWidth  = stpc_pkg::ID_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stpc_pkg::cfg_wr_t cfg_wr_i,
  input  logic             step_i,
  input  stpc_pkg::req_t   req_i,
  output stpc_pkg::res_t   res_o
);
  import stpc_pkg::*;

  // Identifiers never carry more than the channel width
  localparam int IdW = (IdWidth < ID_W) ? IdWidth : ID_W;

  logic [IdW-1:0]      own_id_q, own_id_d;
  logic [MASK_W-1:0]   port_en_q, port_en_d;
  logic [IdW-1:0]      best_root_q, best_root_d;
  logic [DIST_W-1:0]   best_dist_q, best_dist_d;
  logic [IdW-1:0]      best_sender_q, best_sender_d;
  logic [NumPorts-1:0] desig_q, desig_d;
  logic [PORT_W-1:0]   root_port_q, root_port_d;
  logic                has_rp_q, has_rp_d;

  logic [IdW-1:0]      mr, ms;
  logic [DIST_W:0]     md1;
  logic [DIST_W-1:0]   dist_sat;
  logic                port_ok, is_orig;
  logic                root_lower, root_eq, adopt, lose_tie, lose_own;
  logic [NumPorts-1:0] pbit, en_ports, smask;
  logic                send;

  // Message compares
  always_comb begin
    mr         = req_i.msg_root[IdW-1:0];
    ms         = req_i.msg_sender[IdW-1:0];
    md1        = (DIST_W+1)'(req_i.msg_distance) + (DIST_W+1)'(1);
    dist_sat   = md1[DIST_W] ? DIST_MAX : md1[DIST_W-1:0];
    is_orig    = (req_i.req_type == REQ_ORIGINATE);
    port_ok    = (NumPorts >= (1 << PORT_W)) || (int'(req_i.arrival_port) < NumPorts);
    pbit       = NumPorts'(1) << req_i.arrival_port;
    en_ports   = NumPorts'(port_en_q);
    root_lower = (mr < best_root_q);
    root_eq    = (mr == best_root_q);
    adopt      = root_lower
               || (root_eq && (md1 < (DIST_W+1)'(best_dist_q)))
               || (root_eq && (md1 == (DIST_W+1)'(best_dist_q)) && (ms < best_sender_q));
    // equal path through a higher sender, or a peer at our own distance
    lose_tie   = root_eq && (md1 == (DIST_W+1)'(best_dist_q)) && (ms > best_sender_q);
    lose_own   = root_eq && (req_i.msg_distance == best_dist_q) && (ms < own_id_q);
  end

  // Next state: register writes, then message updates
  always_comb begin
    own_id_d      = own_id_q;
    port_en_d     = port_en_q;
    best_root_d   = best_root_q;
    best_dist_d   = best_dist_q;
    best_sender_d = best_sender_q;
    desig_d       = desig_q;
    root_port_d   = root_port_q;
    has_rp_d      = has_rp_q;
    if (cfg_wr_i.valid) begin
      unique case (cfg_reg_e'(cfg_wr_i.index))
        CFG_OWN_ID: begin
          own_id_d      = cfg_wr_i.data[IdW-1:0];
          best_root_d   = cfg_wr_i.data[IdW-1:0];
          best_dist_d   = '0;
          best_sender_d = cfg_wr_i.data[IdW-1:0];
          desig_d       = '1;
          root_port_d   = '0;
          has_rp_d      = 1'b0;
        end
        CFG_PORT_ENABLE: begin
          port_en_d = cfg_wr_i.data;
        end
      endcase
    end else if (step_i && !is_orig && port_ok) begin
      if (adopt) begin
        best_root_d   = mr;
        best_sender_d = ms;
        root_port_d   = req_i.arrival_port;
        has_rp_d      = 1'b1;
        if (root_lower || (md1 < (DIST_W+1)'(best_dist_q))) begin
          best_dist_d = dist_sat;
        end
      end
      if (adopt || lose_tie || lose_own) begin
        desig_d = desig_q & ~pbit;
      end
    end
  end

  // Result view of the updated state
  always_comb begin
    send  = is_orig || (port_ok && adopt);
    smask = is_orig ? en_ports : (en_ports & ~pbit);
    res_o.send_valid      = send;
    res_o.out_root        = send ? ID_W'(best_root_d) : '0;
    res_o.out_distance    = send ? best_dist_d : '0;
    res_o.out_sender      = send ? ID_W'(own_id_q) : '0;
    res_o.send_port_mask  = send ? MASK_W'(smask) : '0;
    res_o.designated_mask = MASK_W'(desig_d);
    res_o.root_port       = root_port_d;
    res_o.root_port_valid = has_rp_d;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q      <= '0;
      port_en_q     <= '1;
      best_root_q   <= '0;
      best_dist_q   <= '0;
      best_sender_q <= '0;
      desig_q       <= '1;
      root_port_q   <= '0;
      has_rp_q      <= 1'b0;
    end else begin
      own_id_q      <= own_id_d;
      port_en_q     <= port_en_d;
      best_root_q   <= best_root_d;
      best_dist_q   <= best_dist_d;
      best_sender_q <= best_sender_d;
      desig_q       <= desig_d;
      root_port_q   <= root_port_d;
      has_rp_q      <= has_rp_d;
    end
  end

  // Without a root port the bridge is still its own root
  a_own_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !has_rp_q |-> (best_root_q == own_id_q) && (best_dist_q == '0))
    else $error("no root port but root state is not own");

  // Identifier write restarts the tree state
  a_id_reinit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr_i.valid && (cfg_wr_i.index == CFG_OWN_ID)) |=> (desig_q == '1) && !has_rp_q)
    else $error("own_id write did not reinitialize state");

  // Originate leaves the tree state alone
  a_orig_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && is_orig && !cfg_wr_i.valid) |=>
      $stable(best_root_q) && $stable(best_dist_q) && $stable(best_sender_q)
      && $stable(desig_q) && $stable(has_rp_q))
    else $error("originate request changed state");

endmodule

// File: design/stp_config_bpdu_processor.sv
// Top level: request register, engine, result register and handshakes.
// Depends on stpc_pkg, stpc_if.sv interfaces and stpc_engine.
//
//  Channel | Role       | Transfer when          | Payload
//  req_i   | sink       | valid && ready         | req_type, msg_root/distance/sender, port
//  res_o   | source     | valid && ready         | send fields, designated mask, root port
//  cfg_i   | sink       | valid && ready         | index (own_id, port_enable), data
//
// One request per cycle unless res_o stalls; request and result are each registered.
// The decision and state update run when a held request meets a free result slot.
// Reset (rst_ni low, async): own_id 0, all ports enabled, bridge is its own root.
// A stalled result holds the result and any held request; cfg_i is always ready.
module stp_config_bpdu_processor #(
  parameter int NumPorts = stpc_pkg::NUM_PORTS_DEF,
  parameter int IdWidth  = stpc_pkg::ID_WIDTH_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  stpc_req_if.sink   req_i,
  stpc_res_if.source res_o,
  stpc_cfg_if.sink   cfg_i
);
  import stpc_pkg::*;

  req_t    req_q;
  logic    req_vld_q;
  res_t    res_q, res_d;
  logic    res_vld_q;
  logic    fire;
  cfg_wr_t cfg_wr;

  // Work happens when the request register is full and the result slot frees up
  assign fire        = req_vld_q && (!res_vld_q || res_o.ready);
  assign req_i.ready = !req_vld_q || fire;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_wr.valid = cfg_i.valid;
    cfg_wr.index = cfg_i.index;
    cfg_wr.data  = cfg_i.data;
  end

  // Request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      req_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q.req_type     <= req_i.req_type;
      req_q.msg_root     <= req_i.msg_root;
      req_q.msg_distance <= req_i.msg_distance;
      req_q.msg_sender   <= req_i.msg_sender;
      req_q.arrival_port <= req_i.arrival_port;
    end
  end

  stpc_engine #(
    .NumPorts (NumPorts),
    .IdWidth  (IdWidth)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_wr_i (cfg_wr),
    .step_i   (fire),
    .req_i    (req_q),
    .res_o    (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (fire) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid           = res_vld_q;
  assign res_o.send_valid      = res_q.send_valid;
  assign res_o.out_root        = res_q.out_root;
  assign res_o.out_distance    = res_q.out_distance;
  assign res_o.out_sender      = res_q.out_sender;
  assign res_o.send_port_mask  = res_q.send_port_mask;
  assign res_o.designated_mask = res_q.designated_mask;
  assign res_o.root_port       = res_q.root_port;
  assign res_o.root_port_valid = res_q.root_port_valid;

  // A processed request always leaves a result behind
  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> res_vld_q)
    else $error("processed request produced no result");

  // A waiting request is neither lost nor altered
  a_req_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_vld_q && !fire) |=> req_vld_q && $stable(req_q))
    else $error("pending request dropped or changed");

  // A result not taken stays put
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && !res_o.ready) |=> res_vld_q)
    else $error("result dropped while stalled");

endmodule
